/* rtl/sbc_pkg.sv */
// shared constants, config struct and helper functions for the segment/box crossing block
package sbc_pkg;

    // geometry and number formats
    localparam int NDIM    = 3;
    localparam int DIM_W   = 2;
    localparam int COORD_W = 32;
    localparam int EPS_W   = 16;
    localparam int T_W     = 30;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int TQ_W    = T_W + 1;
    localparam int PROD_W  = TQ_W + HALF_W;
    localparam int ACC_W   = 63;
    localparam int RHS_W   = DIFF_W + EPS_W + 1;
    localparam int STAT_W  = 2;
    localparam int CODE_W  = 3;

    // configuration port
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [REG_W-1:0] REG_MAX_X = 3'd1;
    localparam logic [REG_W-1:0] REG_MIN_Y = 3'd2;
    localparam logic [REG_W-1:0] REG_MAX_Y = 3'd3;
    localparam logic [REG_W-1:0] REG_MIN_Z = 3'd4;
    localparam logic [REG_W-1:0] REG_MAX_Z = 3'd5;
    localparam logic [REG_W-1:0] REG_MASK  = 3'd6;
    localparam logic [REG_W-1:0] REG_EPS   = 3'd7;

    localparam logic [NDIM-1:0] MASK_RESET = 3'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_BOTH_IN  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MIXED    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BOTH_OUT = 2'd2;

    // rounding constant for the interpolation, half of one t unit
    localparam logic [ACC_W-1:0] T_HALF = ACC_W'(1) << (T_W - 1);

    typedef struct packed {
        logic [NDIM-1:0][COORD_W-1:0] box_min;
        logic [NDIM-1:0][COORD_W-1:0] box_max;
        logic [NDIM-1:0]              mask;
        logic [EPS_W-1:0]             eps;
    } t_cfg;

    // sign-extended difference a - b, one bit wider than the coordinates
    function automatic logic [DIFF_W-1:0] diff_ext(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    // magnitude of a difference; it always fits the coordinate width
    function automatic logic [MAG_W-1:0] mag_of(input logic [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] n;
        n = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
        return n[MAG_W-1:0];
    endfunction

endpackage

/* rtl/sbc_regs.sv */
// configuration register file behind the apb-style port
module sbc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbc_pkg::DATA_W-1:0]  pwdata,
    output logic [sbc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output sbc_pkg::t_cfg               o_cfg
);
    import sbc_pkg::*;

    logic [NDIM-1:0][COORD_W-1:0] r_min;
    logic [NDIM-1:0][COORD_W-1:0] r_max;
    logic [NDIM-1:0]              r_mask;
    logic [EPS_W-1:0]             r_eps;
    logic [REG_W-1:0]             w_idx;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    // register writes on the access phase of a write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= '0;
            r_max  <= '0;
            r_mask <= MASK_RESET;
            r_eps  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MIN_X: r_min[0] <= pwdata[COORD_W-1:0];
                REG_MAX_X: r_max[0] <= pwdata[COORD_W-1:0];
                REG_MIN_Y: r_min[1] <= pwdata[COORD_W-1:0];
                REG_MAX_Y: r_max[1] <= pwdata[COORD_W-1:0];
                REG_MIN_Z: r_min[2] <= pwdata[COORD_W-1:0];
                REG_MAX_Z: r_max[2] <= pwdata[COORD_W-1:0];
                REG_MASK:  r_mask   <= pwdata[NDIM-1:0];
                REG_EPS:   r_eps    <= pwdata[EPS_W-1:0];
                default:   r_eps    <= r_eps;
            endcase
        end
    end

    // read data mux
    always_comb begin
        case (w_idx)
            REG_MIN_X: prdata = r_min[0];
            REG_MAX_X: prdata = r_max[0];
            REG_MIN_Y: prdata = r_min[1];
            REG_MAX_Y: prdata = r_max[1];
            REG_MIN_Z: prdata = r_min[2];
            REG_MAX_Z: prdata = r_max[2];
            REG_MASK:  prdata = DATA_W'(r_mask);
            REG_EPS:   prdata = DATA_W'(r_eps);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.box_min = r_min;
    assign o_cfg.box_max = r_max;
    assign o_cfg.mask    = r_mask;
    assign o_cfg.eps     = r_eps;

endmodule

/* rtl/sbc_div.sv */
// iterative restoring divider for the crossing parameter t = num * 2^30 / den
module sbc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sbc_pkg::MAG_W-1:0]  i_num,
    input  logic [sbc_pkg::MAG_W-1:0]  i_den,
    output logic                       o_done,
    output logic [sbc_pkg::TQ_W-1:0]   o_quo
);
    import sbc_pkg::*;

    localparam int STEPS = TQ_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic               r_run;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W:0]     r_rem;
    logic [MAG_W-1:0]   r_den;
    logic [TQ_W-1:0]    r_quo;
    logic               w_ge;
    logic [MAG_W:0]     w_rem;

    // one quotient bit per cycle: compare and subtract
    assign w_ge  = r_rem >= {1'b0, r_den};
    assign w_rem = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(STEPS);
                r_rem <= {1'b0, i_num};
                r_den <= i_den;
                r_quo <= '0;
            end else if (r_run) begin
                r_quo <= {r_quo[TQ_W-2:0], w_ge};
                r_rem <= {w_rem[MAG_W-1:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/sbc_interp.sv */
// interpolation of one coordinate: hit = q + sign(d) * round(t * |d| / 2^30)
module sbc_interp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sbc_pkg::TQ_W-1:0]    i_t,
    input  logic [sbc_pkg::DIFF_W-1:0]  i_d,
    input  logic [sbc_pkg::COORD_W-1:0] i_q,
    output logic                        o_done,
    output logic [sbc_pkg::COORD_W-1:0] o_hit
);
    import sbc_pkg::*;

    localparam logic [2:0] I_IDLE = 3'd0;
    localparam logic [2:0] I_LO   = 3'd1;
    localparam logic [2:0] I_HI   = 3'd2;
    localparam logic [2:0] I_ACC  = 3'd3;
    localparam logic [2:0] I_OUT  = 3'd4;

    logic [2:0]          r_state;
    logic                r_done;
    logic [TQ_W-1:0]     r_t;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    logic [COORD_W-1:0]  r_q;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [COORD_W-1:0]  r_hit;
    logic [ACC_W-T_W-1:0] w_m;

    assign w_m = r_acc[ACC_W-1:T_W];

    // two half-width partial products, then accumulate and round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= I_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                I_IDLE: begin
                    if (i_start) begin
                        r_t     <= i_t;
                        r_mag   <= mag_of(i_d);
                        r_neg   <= i_d[DIFF_W-1];
                        r_q     <= i_q;
                        r_state <= I_LO;
                    end
                end
                I_LO: begin
                    r_prod  <= r_t * r_mag[HALF_W-1:0];
                    r_state <= I_HI;
                end
                I_HI: begin
                    r_acc   <= ACC_W'(r_prod);
                    r_prod  <= r_t * r_mag[MAG_W-1:HALF_W];
                    r_state <= I_ACC;
                end
                I_ACC: begin
                    r_acc   <= r_acc + {r_prod, {HALF_W{1'b0}}} + T_HALF;
                    r_state <= I_OUT;
                end
                I_OUT: begin
                    r_hit   <= r_neg ? (r_q - w_m[COORD_W-1:0]) : (r_q + w_m[COORD_W-1:0]);
                    r_done  <= 1'b1;
                    r_state <= I_IDLE;
                end
                default: r_state <= I_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hit  = r_hit;

endmodule

/* rtl/segment_box_crossing_core.sv */
// top level: segment against configured box, classification and crossing sequencer
//
// A segment is taken at a clock edge with start high and busy low. The block
// then works on it alone: the sequencer walks the dimensions one at a time
// with the single 31-step divider and an interpolator reused per coordinate.
// A segment with both ends inside or both outside returns once all dimensions
// are classified. A mixed segment takes skip, magnitude, threshold and face
// steps per dimension scanned (ending after magnitude at zero length, after
// threshold below the skip threshold); a crossing then adds the division and
// an interpolation per coordinate. The result is shown for exactly one cycle
// with o_done high and cannot be held off by the receiver; busy falls in that
// same cycle, so the next segment may start there. Box registers are to be
// written over the apb-style port only while idle; the block never checks.
module segment_box_crossing_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sbc_pkg::ADDR_W-1:0]          paddr,
    input  logic [sbc_pkg::DATA_W-1:0]          pwdata,
    output logic [sbc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // segment input
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sbc_pkg::COORD_W-1:0]  i_p_x,
    input  logic signed [sbc_pkg::COORD_W-1:0]  i_p_y,
    input  logic signed [sbc_pkg::COORD_W-1:0]  i_p_z,
    input  logic signed [sbc_pkg::COORD_W-1:0]  i_q_x,
    input  logic signed [sbc_pkg::COORD_W-1:0]  i_q_y,
    input  logic signed [sbc_pkg::COORD_W-1:0]  i_q_z,
    // result
    output logic                                o_done,
    output logic [sbc_pkg::STAT_W-1:0]          o_status,
    output logic                                o_crossing_found,
    output logic signed [sbc_pkg::COORD_W-1:0]  o_hit_x,
    output logic signed [sbc_pkg::COORD_W-1:0]  o_hit_y,
    output logic signed [sbc_pkg::COORD_W-1:0]  o_hit_z,
    output logic [sbc_pkg::CODE_W-1:0]          o_edge_code
);
    import sbc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLS  = 4'd1;
    localparam logic [3:0] S_STAT = 4'd2;
    localparam logic [3:0] S_SKIP = 4'd3;
    localparam logic [3:0] S_MAG  = 4'd4;
    localparam logic [3:0] S_THR  = 4'd5;
    localparam logic [3:0] S_FACE = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DI   = 4'd8;
    localparam logic [3:0] S_IST  = 4'd9;
    localparam logic [3:0] S_IW   = 4'd10;

    localparam logic [DIM_W-1:0] DIM_FIRST = '0;
    localparam logic [DIM_W-1:0] DIM_LAST  = DIM_W'(NDIM - 1);
    localparam logic             FACE_MIN  = 1'b0;
    localparam logic             FACE_MAX  = 1'b1;

    t_cfg                          w_cfg;
    logic [3:0]                    r_state;
    logic                          r_done;
    logic [NDIM-1:0][COORD_W-1:0]  r_p;
    logic [NDIM-1:0][COORD_W-1:0]  r_q;
    logic [DIM_W-1:0]              r_dim;
    logic                          r_pin;
    logic                          r_qin;
    logic [DIFF_W-1:0]             r_d;
    logic signed [RHS_W-1:0]       r_rhs;
    logic [MAG_W-1:0]              r_dmag;
    logic                          r_dneg;
    logic [DIFF_W-1:0]             r_nmin;
    logic [DIFF_W-1:0]             r_nmax;
    logic [TQ_W-1:0]               r_t;
    logic [STAT_W-1:0]             r_status;
    logic                          r_found;
    logic [NDIM-1:0][COORD_W-1:0]  r_hit;
    logic [CODE_W-1:0]             r_code;

    logic                          w_p_ok;
    logic                          w_q_ok;
    logic [DIFF_W-1:0]             w_span;
    logic signed [RHS_W-1:0]       w_lhs;
    logic [MAG_W-1:0]              w_nmin_mag;
    logic [MAG_W-1:0]              w_nmax_mag;
    logic                          w_min_ok;
    logic                          w_max_ok;
    logic [CODE_W-1:0]             w_code_base;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [TQ_W-1:0]               w_div_quo;
    logic                          w_int_done;
    logic [COORD_W-1:0]            w_int_hit;

    sbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // inside test of both ends in the current dimension, inclusive bounds
    assign w_p_ok = ($signed(r_p[r_dim]) >= $signed(w_cfg.box_min[r_dim]))
                 && ($signed(r_p[r_dim]) <= $signed(w_cfg.box_max[r_dim]));
    assign w_q_ok = ($signed(r_q[r_dim]) >= $signed(w_cfg.box_min[r_dim]))
                 && ($signed(r_q[r_dim]) <= $signed(w_cfg.box_max[r_dim]));

    // skip threshold: |d| * 2^16 against span * epsilon
    assign w_span = diff_ext(w_cfg.box_max[r_dim], w_cfg.box_min[r_dim]);
    assign w_lhs  = $signed({2'b00, r_dmag, {EPS_W{1'b0}}});

    // face crossing lies within the segment when num/d is in [0,1]
    assign w_nmin_mag = mag_of(r_nmin);
    assign w_nmax_mag = mag_of(r_nmax);
    assign w_min_ok = (r_nmin == '0)
                   || ((r_nmin[DIFF_W-1] == r_dneg) && (w_nmin_mag <= r_dmag));
    assign w_max_ok = (r_nmax == '0)
                   || ((r_nmax[DIFF_W-1] == r_dneg) && (w_nmax_mag <= r_dmag));
    assign w_code_base = {1'b0, r_dim} + {r_dim, 1'b0};

    assign w_div_start = (r_state == S_FACE) && (w_min_ok || w_max_ok);

    sbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_max_ok ? w_nmax_mag : w_nmin_mag),
        .i_den   (r_dmag),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    sbc_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_IST),
        .i_t     (r_t),
        .i_d     (r_d),
        .i_q     (r_q[r_dim]),
        .o_done  (w_int_done),
        .o_hit   (w_int_hit)
    );

    // sequencer: classify, scan dimensions, divide, interpolate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_p     <= {i_p_z, i_p_y, i_p_x};
                        r_q     <= {i_q_z, i_q_y, i_q_x};
                        r_dim   <= DIM_FIRST;
                        r_pin   <= 1'b1;
                        r_qin   <= 1'b1;
                        r_state <= S_CLS;
                    end
                end
                S_CLS: begin
                    if (w_cfg.mask[r_dim]) begin
                        r_pin <= r_pin && w_p_ok;
                        r_qin <= r_qin && w_q_ok;
                    end
                    if (r_dim == DIM_LAST) begin
                        r_state <= S_STAT;
                    end else begin
                        r_dim <= r_dim + DIM_W'(1);
                    end
                end
                S_STAT: begin
                    r_found <= 1'b0;
                    r_hit   <= '0;
                    r_code  <= '0;
                    if (r_pin && r_qin) begin
                        r_status <= STAT_BOTH_IN;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (!r_pin && !r_qin) begin
                        r_status <= STAT_BOTH_OUT;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_status <= STAT_MIXED;
                        r_dim    <= DIM_FIRST;
                        r_state  <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    r_d     <= diff_ext(r_p[r_dim], r_q[r_dim]);
                    r_rhs   <= $signed(w_span) * $signed({1'b0, w_cfg.eps});
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_dmag <= mag_of(r_d);
                    r_dneg <= r_d[DIFF_W-1];
                    if (r_d == '0) begin
                        if (r_dim == DIM_LAST) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_dim   <= r_dim + DIM_W'(1);
                            r_state <= S_SKIP;
                        end
                    end else begin
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    r_nmin <= diff_ext(w_cfg.box_min[r_dim], r_q[r_dim]);
                    r_nmax <= diff_ext(w_cfg.box_max[r_dim], r_q[r_dim]);
                    if (w_lhs > r_rhs) begin
                        r_state <= S_FACE;
                    end else if (r_dim == DIM_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_dim   <= r_dim + DIM_W'(1);
                        r_state <= S_SKIP;
                    end
                end
                S_FACE: begin
                    // the max face wins when both qualify
                    if (w_max_ok) begin
                        r_code  <= w_code_base + CODE_W'(FACE_MAX);
                        r_state <= S_DIV;
                    end else if (w_min_ok) begin
                        r_code  <= w_code_base + CODE_W'(FACE_MIN);
                        r_state <= S_DIV;
                    end else if (r_dim == DIM_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_dim   <= r_dim + DIM_W'(1);
                        r_state <= S_SKIP;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_t     <= w_div_quo;
                        r_dim   <= DIM_FIRST;
                        r_state <= S_DI;
                    end
                end
                S_DI: begin
                    r_d     <= diff_ext(r_p[r_dim], r_q[r_dim]);
                    r_state <= S_IST;
                end
                S_IST: begin
                    r_state <= S_IW;
                end
                S_IW: begin
                    if (w_int_done) begin
                        r_hit[r_dim] <= w_int_hit;
                        if (r_dim == DIM_LAST) begin
                            r_found <= 1'b1;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_dim   <= r_dim + DIM_W'(1);
                            r_state <= S_DI;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_crossing_found = r_found;
    assign o_hit_x          = r_hit[0];
    assign o_hit_y          = r_hit[1];
    assign o_hit_z          = r_hit[2];
    assign o_edge_code      = r_code;

endmodule

/* tb/sbc_crossing_checker.sv */
// checker for the segment/box crossing core: tracks the box registers, predicts and compares results
module sbc_crossing_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port, observed
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [sbc_pkg::ADDR_W-1:0]          paddr,
    input  logic [sbc_pkg::DATA_W-1:0]          pwdata,
    // segment channel, observed
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [sbc_pkg::COORD_W-1:0]         i_p_x,
    input  logic [sbc_pkg::COORD_W-1:0]         i_p_y,
    input  logic [sbc_pkg::COORD_W-1:0]         i_p_z,
    input  logic [sbc_pkg::COORD_W-1:0]         i_q_x,
    input  logic [sbc_pkg::COORD_W-1:0]         i_q_y,
    input  logic [sbc_pkg::COORD_W-1:0]         i_q_z,
    // result channel, observed
    input  logic                                i_done,
    input  logic [sbc_pkg::STAT_W-1:0]          i_status,
    input  logic                                i_crossing_found,
    input  logic [sbc_pkg::COORD_W-1:0]         i_hit_x,
    input  logic [sbc_pkg::COORD_W-1:0]         i_hit_y,
    input  logic [sbc_pkg::COORD_W-1:0]         i_hit_z,
    input  logic [sbc_pkg::CODE_W-1:0]          i_edge_code,
    // to the testbench top
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import sbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;
    typedef logic [NDIM-1:0][COORD_W-1:0] t_coord_vec;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        t_coord_vec         hit;
        logic [CODE_W-1:0]  code;
    } t_crossing_result;

    // face side within a dimension, and the edge code step per dimension
    localparam int SIDE_MIN        = 0;
    localparam int SIDE_MAX        = 1;
    localparam int CODE_DIM_STRIDE = 3;
    localparam int REPORT_LIMIT    = 10;

    localparam t_u64 T_ROUND = t_u64'(1) << (T_W - 1);

    // local copy of the box registers
    longint             box_lo [NDIM];
    longint             box_hi [NDIM];
    logic [NDIM-1:0]    box_mask;
    logic [EPS_W-1:0]   box_eps;

    t_crossing_result   expected_crossings [$];
    int                 fails;

    function automatic t_u64 mag64(input longint v);
        return (v < 0) ? t_u64'(-v) : t_u64'(v);
    endfunction

    // num/den lies in [0,1], den nonzero
    function automatic bit ratio_in_unit(input longint num, input longint den);
        if (num == 0) return 1'b1;
        if ((num < 0) != (den < 0)) return 1'b0;
        return mag64(num) <= mag64(den);
    endfunction

    function automatic t_crossing_result predict_crossing(input t_coord_vec p_raw,
                                                          input t_coord_vec q_raw);
        t_crossing_result res;
        longint           p [NDIM];
        longint           q [NDIM];
        longint           d, span, lhs, rhs, num, dj;
        t_u64             t, m, h;
        bit               p_in, q_in;
        res  = '0;
        p_in = 1'b1;
        q_in = 1'b1;
        // inside test over the masked dimensions
        for (int i = 0; i < NDIM; i++) begin
            p[i] = longint'(signed'(p_raw[i]));
            q[i] = longint'(signed'(q_raw[i]));
            if (box_mask[i]) begin
                if (p[i] < box_lo[i] || p[i] > box_hi[i]) p_in = 1'b0;
                if (q[i] < box_lo[i] || q[i] > box_hi[i]) q_in = 1'b0;
            end
        end
        if (p_in && q_in) res.status = STAT_BOTH_IN;
        else if (!p_in && !q_in) res.status = STAT_BOTH_OUT;
        else res.status = STAT_MIXED;
        // scan dimensions in order, max face overrides min face
        if (res.status == STAT_MIXED) begin
            for (int i = 0; i < NDIM; i++) begin
                d    = p[i] - q[i];
                span = box_hi[i] - box_lo[i];
                lhs  = longint'(mag64(d) << EPS_W);
                rhs  = span * longint'(box_eps);
                if (!res.found && d != 0 && lhs > rhs) begin
                    for (int side = SIDE_MIN; side <= SIDE_MAX; side++) begin
                        num = ((side == SIDE_MAX) ? box_hi[i] : box_lo[i]) - q[i];
                        if (ratio_in_unit(num, d)) begin
                            t = (mag64(num) << T_W) / mag64(d);
                            for (int j = 0; j < NDIM; j++) begin
                                dj = p[j] - q[j];
                                m  = (t * mag64(dj) + T_ROUND) >> T_W;
                                h  = (dj < 0) ? t_u64'(q[j]) - m : t_u64'(q[j]) + m;
                                res.hit[j] = h[COORD_W-1:0];
                            end
                            res.found = 1'b1;
                            res.code  = CODE_W'(i * CODE_DIM_STRIDE + side);
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // register writes, segment transfers and result transfers
    always @(posedge i_clk) begin
        t_crossing_result seen;
        t_crossing_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NDIM; i++) begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            box_mask = MASK_RESET;
            box_eps  = '0;
            expected_crossings.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_MIN_X: box_lo[0] = longint'(signed'(pwdata));
                    REG_MAX_X: box_hi[0] = longint'(signed'(pwdata));
                    REG_MIN_Y: box_lo[1] = longint'(signed'(pwdata));
                    REG_MAX_Y: box_hi[1] = longint'(signed'(pwdata));
                    REG_MIN_Z: box_lo[2] = longint'(signed'(pwdata));
                    REG_MAX_Z: box_hi[2] = longint'(signed'(pwdata));
                    REG_MASK:  box_mask  = pwdata[NDIM-1:0];
                    REG_EPS:   box_eps   = pwdata[EPS_W-1:0];
                    default: ;
                endcase
            end
            // a result transfer is checked against the oldest segment
            if (i_done) begin
                seen.status = i_status;
                seen.found  = i_crossing_found;
                seen.hit    = {i_hit_z, i_hit_y, i_hit_x};
                seen.code   = i_edge_code;
                if (expected_crossings.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: crossing result with no segment outstanding", $realtime);
                end else begin
                    want = expected_crossings.pop_front();
                    if (seen.status !== want.status || seen.found !== want.found ||
                        seen.hit !== want.hit || seen.code !== want.code) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: crossing mismatch, expected status %0d found %0b",
                                     $realtime, want.status, want.found);
                            $display("    hit %h %h %h edge %0d", want.hit[0], want.hit[1],
                                     want.hit[2], want.code);
                            $display("    observed status %0d found %0b", seen.status,
                                     seen.found);
                            $display("    hit %h %h %h edge %0d", seen.hit[0], seen.hit[1],
                                     seen.hit[2], seen.code);
                        end
                    end
                end
            end
            // queue the prediction for an accepted segment at the tail
            if (i_start && !i_busy)
                expected_crossings = {expected_crossings,
                                      predict_crossing({i_p_z, i_p_y, i_p_x},
                                                       {i_q_z, i_q_y, i_q_x})};
        end
        o_fail_count <= fails;
        o_pending    <= expected_crossings.size();
    end

endmodule

/* tb/tb_segment_box_crossing_core.sv */
// testbench top for the segment/box crossing core: stimulus, register setup and verdict
module tb_segment_box_crossing_core;
    import sbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    localparam int     RAND_PHASES     = 6;
    localparam int     ITEMS_PER_PHASE = 122;
    localparam int     QUIET_PHASE     = 2;
    localparam int     IDLE_PERCENT    = 28;
    localparam int     MAX_GAP         = 40;
    localparam int     TAIL_CYCLES     = 100;
    localparam int     WATCHDOG_LIMIT  = 5000;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [ADDR_W-1:0]          paddr   = '0;
    logic [DATA_W-1:0]          pwdata  = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       start   = 1'b0;
    logic                       busy;
    logic signed [COORD_W-1:0]  i_p_x   = '0;
    logic signed [COORD_W-1:0]  i_p_y   = '0;
    logic signed [COORD_W-1:0]  i_p_z   = '0;
    logic signed [COORD_W-1:0]  i_q_x   = '0;
    logic signed [COORD_W-1:0]  i_q_y   = '0;
    logic signed [COORD_W-1:0]  i_q_z   = '0;
    logic                       o_done;
    logic [STAT_W-1:0]          o_status;
    logic                       o_crossing_found;
    logic signed [COORD_W-1:0]  o_hit_x;
    logic signed [COORD_W-1:0]  o_hit_y;
    logic signed [COORD_W-1:0]  o_hit_z;
    logic [CODE_W-1:0]          o_edge_code;

    int                         fail_count;
    int                         pending;
    int                         quiet_cycles;
    bit                         sender_idles = 1'b1;

    // box setting currently programmed, used to aim the segments
    logic [NDIM-1:0][COORD_W-1:0] cur_lo;
    logic [NDIM-1:0][COORD_W-1:0] cur_hi;
    logic [NDIM-1:0]              cur_mask;
    logic [EPS_W-1:0]             cur_eps;

    segment_box_crossing_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .start            (start),
        .busy             (busy),
        .i_p_x            (i_p_x),
        .i_p_y            (i_p_y),
        .i_p_z            (i_p_z),
        .i_q_x            (i_q_x),
        .i_q_y            (i_q_y),
        .i_q_z            (i_q_z),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_crossing_found (o_crossing_found),
        .o_hit_x          (o_hit_x),
        .o_hit_y          (o_hit_y),
        .o_hit_z          (o_hit_z),
        .o_edge_code      (o_edge_code)
    );

    sbc_crossing_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .i_start          (start),
        .i_busy           (busy),
        .i_p_x            (i_p_x),
        .i_p_y            (i_p_y),
        .i_p_z            (i_p_z),
        .i_q_x            (i_q_x),
        .i_q_y            (i_q_y),
        .i_q_z            (i_q_z),
        .i_done           (o_done),
        .i_status         (o_status),
        .i_crossing_found (o_crossing_found),
        .i_hit_x          (o_hit_x),
        .i_hit_y          (o_hit_y),
        .i_hit_z          (o_hit_z),
        .i_edge_code      (o_edge_code),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_segment_box_crossing_core NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [COORD_W-1:0] fx(input int whole);
        return COORD_W'(whole) << 16;
    endfunction

    function automatic logic [COORD_W-1:0] clip32(input longint v);
        if (v > COORD_MAX) return COORD_W'(COORD_MAX);
        if (v < COORD_MIN) return COORD_W'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    function automatic longint lo_of(input int i);
        return longint'(signed'(cur_lo[i]));
    endfunction

    function automatic longint hi_of(input int i);
        return longint'(signed'(cur_hi[i]));
    endfunction

    // signed value with a random order of magnitude
    function automatic longint rand_scaled();
        int v;
        v = $urandom;
        return longint'(v >>> $urandom_range(0, 31));
    endfunction

    function automatic longint rand_magnitude();
        int unsigned w;
        w = $urandom;
        return longint'(w >> $urandom_range(0, 31));
    endfunction

    function automatic logic [COORD_W-1:0] pick_inside(input int i);
        longint lo, hi;
        t_u64   r;
        lo = lo_of(i);
        hi = hi_of(i);
        if (hi <= lo) return cur_lo[i];
        r = {$urandom, $urandom};
        return clip32(lo + longint'(r % t_u64'(hi - lo + 1)));
    endfunction

    // coordinate on, just off, far off or inside the faces of one dimension, or random
    function automatic logic [COORD_W-1:0] pick_near(input int i);
        longint v;
        case ($urandom_range(0, 5))
            0: v = lo_of(i) - longint'($urandom_range(0, 15));
            1: v = hi_of(i) + longint'($urandom_range(0, 15));
            2: v = lo_of(i) - rand_magnitude();
            3: v = hi_of(i) + rand_magnitude();
            4: return pick_inside(i);
            default: v = rand_scaled();
        endcase
        return clip32(v);
    endfunction

    // one register write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_box();
        apb_write(REG_MIN_X, cur_lo[0]);
        apb_write(REG_MAX_X, cur_hi[0]);
        apb_write(REG_MIN_Y, cur_lo[1]);
        apb_write(REG_MAX_Y, cur_hi[1]);
        apb_write(REG_MIN_Z, cur_lo[2]);
        apb_write(REG_MAX_Z, cur_hi[2]);
        apb_write(REG_MASK, DATA_W'(cur_mask));
        apb_write(REG_EPS, DATA_W'(cur_eps));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_bounds(input int dim, input logic [COORD_W-1:0] lo,
                              input logic [COORD_W-1:0] hi);
        cur_lo[dim] = lo;
        cur_hi[dim] = hi;
    endtask

    // drop start and wait until every segment has its result
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // one segment transfer, with an optional sender gap ahead of it
    task automatic send_segment(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                                input logic [COORD_W-1:0] pz, input logic [COORD_W-1:0] qx,
                                input logic [COORD_W-1:0] qy, input logic [COORD_W-1:0] qz);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 99) < IDLE_PERCENT)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_p_x <= px;
        i_p_y <= py;
        i_p_z <= pz;
        i_q_x <= qx;
        i_q_y <= qy;
        i_q_z <= qz;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic run_directed();
        // reset box collapses to the origin: both x faces meet and the max face wins
        send_segment(0, 0, fx(3), fx(1), 0, 0);
        send_segment(0, 0, 0, 0, 0, 0);

        wait_idle();
        set_bounds(0, fx(-10), fx(10));
        set_bounds(1, fx(-5), fx(5));
        set_bounds(2, fx(-2), fx(2));
        cur_mask = 3'b111;
        cur_eps  = '0;
        program_box();
        send_segment(fx(1), fx(1), fx(1), fx(-1), fx(-1), fx(-1));
        send_segment(fx(20), 0, 0, fx(30), 0, 0);
        send_segment(fx(-20), 0, 0, fx(20), 0, 0);
        send_segment(0, 0, 0, fx(20), 0, 0);
        send_segment(fx(-30), fx(1), fx(1), 0, 0, 0);
        send_segment(0, 0, 0, 0, fx(8), 0);
        send_segment(0, 0, 0, 0, 0, fx(-3));
        // oblique segment with fractional coordinates, exercises rounding
        send_segment(32'h0003_8001, 32'hfffe_2b07, 32'h0000_7fff,
                     fx(13) + 5, fx(-7) + 3, fx(3));
        // end points lying on a face
        send_segment(fx(10), 0, 0, fx(11), 0, 0);
        send_segment(fx(20), 0, 0, fx(10), 0, 0);
        // coordinate extremes
        send_segment(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0);
        send_segment(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);

        // x left out of the inside test: both x faces cross, max face wins
        wait_idle();
        cur_mask = 3'b110;
        program_box();
        send_segment(fx(-20), 0, 0, fx(20), fx(8), 0);

        // empty mask: every point counts as inside
        wait_idle();
        cur_mask = '0;
        program_box();
        send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

        // largest epsilon: short runs are skipped, long ones still cross
        wait_idle();
        cur_mask = 3'b111;
        cur_eps  = '1;
        program_box();
        send_segment(0, 0, 0, fx(11), 0, 0);
        send_segment(0, 0, 0, 0, 0, fx(30));

        // full-range box in x and y, flat in z
        wait_idle();
        set_bounds(0, 32'h8000_0000, 32'h7fff_ffff);
        set_bounds(1, 32'h8000_0000, 32'h7fff_ffff);
        set_bounds(2, 0, 0);
        cur_eps = '0;
        program_box();
        send_segment(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, fx(1));

        // inverted y bounds, untested then tested
        wait_idle();
        set_bounds(0, fx(-10), fx(10));
        set_bounds(1, fx(5), fx(-5));
        set_bounds(2, fx(-2), fx(2));
        cur_mask = 3'b101;
        program_box();
        send_segment(0, 0, 0, fx(20), 0, 0);
        wait_idle();
        cur_mask = 3'b111;
        program_box();
        send_segment(0, 0, 0, fx(20), 0, 0);
    endtask

    task automatic randomize_box(input int phase);
        longint lo, hi;
        for (int i = 0; i < NDIM; i++) begin
            lo = rand_scaled();
            case ($urandom_range(0, 15))
                0: hi = lo - 1 - rand_magnitude();
                1: hi = lo;
                default: hi = lo + rand_magnitude();
            endcase
            if (phase == 0) begin
                lo = COORD_MIN;
                hi = COORD_MAX;
            end
            cur_lo[i] = clip32(lo);
            cur_hi[i] = clip32(hi);
        end
        cur_mask = ($urandom_range(0, 3) == 0) ? NDIM'($urandom_range(0, 7)) : '1;
        case ($urandom_range(0, 3))
            0: cur_eps = '0;
            1: cur_eps = '1;
            2: cur_eps = EPS_W'($urandom_range(0, 255));
            default: cur_eps = EPS_W'($urandom_range(0, 65535));
        endcase
        if (phase == 0) cur_eps = '0;
        if (phase == 1) cur_eps = '1;
    endtask

    // mostly one end inside and one near the faces, some noise
    task automatic send_random_segment();
        logic [NDIM-1:0][COORD_W-1:0] a;
        logic [NDIM-1:0][COORD_W-1:0] b;
        int                           kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < NDIM; i++) begin
            if (kind < 60) begin
                a[i] = cur_mask[i] ? pick_inside(i) : pick_near(i);
                b[i] = pick_near(i);
            end else if (kind < 75) begin
                a[i] = pick_near(i);
                b[i] = pick_near(i);
            end else if (kind < 90) begin
                a[i] = $urandom;
                b[i] = $urandom;
            end else begin
                a[i] = $urandom_range(0, 1) ? cur_lo[i] : cur_hi[i];
                b[i] = ($urandom_range(0, 3) == 0) ? a[i] : pick_near(i);
            end
        end
        if ($urandom_range(0, 1))
            send_segment(a[0], a[1], a[2], b[0], b[1], b[2]);
        else
            send_segment(b[0], b[1], b[2], a[0], a[1], a[2]);
    endtask

    // main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle();
            randomize_box(phase);
            program_box();
            sender_idles = (phase != QUIET_PHASE);
            repeat (ITEMS_PER_PHASE) send_random_segment();
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_segment_box_crossing_core OK");
        end else begin
            $display("tb_segment_box_crossing_core NOT OK");
        end
        $finish;
    end

endmodule
